### hdl/u8u16_pkg.sv
// Shared types, constants and the lead-byte decode function for the UTF-8 to UTF-16 decoder.
package u8u16_pkg;

    localparam logic [15:0] REPLACEMENT = 16'hFFFD;
    localparam logic [7:0]  LEAD_TWO    = 8'hC2;
    localparam logic [7:0]  LEAD_THREE  = 8'hE0;
    localparam logic [7:0]  LEAD_FOUR   = 8'hF0;
    localparam logic [7:0]  LEAD_BAD    = 8'hF5;
    localparam logic [7:0]  CONT_MASK   = 8'hC0;
    localparam logic [7:0]  CONT_MARK   = 8'h80;

    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = 2;
    localparam int CNT_W       = 3;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        string_end;
        logic        last_of_run;
    } result_t;

    // Up to two results produced by one input byte.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } decode_t;

    typedef struct packed {
        logic        emit;
        logic [15:0] unit;
        logic        is_end;
        logic [20:0] partial;
        logic [1:0]  pending;
    } lead_t;

    // Decode a byte that arrives while no sequence is pending.
    function automatic lead_t lead_decode(input logic [7:0] b);
        lead_t l;
        l.emit    = 1'b1;
        l.unit    = REPLACEMENT;
        l.is_end  = 1'b0;
        l.partial = 21'd0;
        l.pending = 2'd0;
        if (b == 8'd0) begin
            l.unit   = 16'd0;
            l.is_end = 1'b1;
        end else if (b < CONT_MARK) begin
            l.unit = {8'd0, b};
        end else if (b < LEAD_TWO) begin
            l.unit = REPLACEMENT;
        end else if (b < LEAD_THREE) begin
            l.emit    = 1'b0;
            l.partial = {16'd0, b[4:0]};
            l.pending = 2'd1;
        end else if (b < LEAD_FOUR) begin
            l.emit    = 1'b0;
            l.partial = {17'd0, b[3:0]};
            l.pending = 2'd2;
        end else if (b < LEAD_BAD) begin
            l.emit    = 1'b0;
            l.partial = {18'd0, b[2:0]};
            l.pending = 2'd3;
        end else begin
            l.unit = REPLACEMENT;
        end
        return l;
    endfunction

endpackage

### hdl/u8u16_if.sv
// Valid/ready stream interfaces for the byte input and the code unit output.
interface u8u16_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface u8u16_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        string_end;
    logic        last_of_run;

    modport source (output valid, output code_unit, output string_end, output last_of_run,
                    input ready);
    modport sink (input valid, input code_unit, input string_end, input last_of_run,
                  output ready);
endinterface

### hdl/u8u16_decode.sv
// Sequence state and single-pass decode of one byte into up to two code units.
module u8u16_decode (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           in_byte,
    output u8u16_pkg::decode_t   dec,
    output logic [1:0]           pending
);

    logic [20:0] partial_reg;
    logic [20:0] partial_next;
    logic [1:0]  pending_reg;
    logic [1:0]  pending_next;

    u8u16_pkg::lead_t lead;
    logic [20:0]      shifted;
    logic [1:0]       pending_dec;

    assign pending = pending_reg;

    always_comb
    begin
        lead         = u8u16_pkg::lead_decode(in_byte);
        shifted      = {partial_reg[14:0], in_byte[5:0]};
        pending_dec  = pending_reg - 2'd1;
        partial_next = partial_reg;
        pending_next = pending_reg;
        dec.count    = 2'd0;
        dec.first    = '{code_unit: lead.unit, string_end: lead.is_end, last_of_run: 1'b1};
        dec.second   = '{code_unit: 16'd0, string_end: 1'b1, last_of_run: 1'b1};

        if (pending_reg == 2'd0) begin
            dec.count    = {1'b0, lead.emit};
            partial_next = lead.partial;
            pending_next = lead.pending;
        end else if (in_byte == 8'd0) begin
            // Sequence cut short by the terminator: replacement, then the end mark.
            dec.count    = 2'd2;
            dec.first    = '{code_unit: u8u16_pkg::REPLACEMENT, string_end: 1'b0,
                             last_of_run: 1'b0};
            partial_next = 21'd0;
            pending_next = 2'd0;
        end else if ((in_byte & u8u16_pkg::CONT_MASK) == u8u16_pkg::CONT_MARK) begin
            pending_next = pending_dec;
            if (pending_dec == 2'd0) begin
                dec.count    = 2'd1;
                dec.first    = '{code_unit: (shifted[20:16] == 5'd0) ? shifted[15:0]
                                                                   : u8u16_pkg::REPLACEMENT,
                                 string_end: 1'b0, last_of_run: 1'b1};
                partial_next = 21'd0;
            end else begin
                partial_next = shifted;
            end
        end else begin
            // Broken continuation: replacement, then the same byte taken as a new lead.
            dec.first    = '{code_unit: u8u16_pkg::REPLACEMENT, string_end: 1'b0,
                             last_of_run: !lead.emit};
            dec.second   = '{code_unit: lead.unit, string_end: lead.is_end, last_of_run: 1'b1};
            dec.count    = lead.emit ? 2'd2 : 2'd1;
            partial_next = lead.partial;
            pending_next = lead.pending;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            partial_reg <= 21'd0;
            pending_reg <= 2'd0;
        end else if (accept) begin
            partial_reg <= partial_next;
            pending_reg <= pending_next;
        end
    end

endmodule

### hdl/u8u16_queue.sv
// Small result queue that takes up to two code units per cycle and hands out one when the output is ready.
module u8u16_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  u8u16_pkg::decode_t            dec,
    output logic                          room,
    output logic [u8u16_pkg::CNT_W-1:0]   count,
    u8u16_unit_if.source                  out_ch
);

    u8u16_pkg::result_t entry_reg [u8u16_pkg::QUEUE_DEPTH];

    logic [u8u16_pkg::PTR_W-1:0] wr_ptr_reg;
    logic [u8u16_pkg::PTR_W-1:0] wr_ptr_next;
    logic [u8u16_pkg::PTR_W-1:0] wr_ptr_plus;
    logic [u8u16_pkg::PTR_W-1:0] rd_ptr_reg;
    logic [u8u16_pkg::PTR_W-1:0] rd_ptr_next;
    logic [u8u16_pkg::CNT_W-1:0] count_reg;
    logic [u8u16_pkg::CNT_W-1:0] count_next;
    logic [1:0]                  push_n;
    logic                        pop;

    assign push_n      = push ? dec.count : 2'd0;
    assign pop         = out_ch.valid && out_ch.ready;
    assign wr_ptr_plus = wr_ptr_reg + 1'b1;
    assign wr_ptr_next = wr_ptr_reg + push_n[u8u16_pkg::PTR_W-1:0];
    assign rd_ptr_next = rd_ptr_reg + {{(u8u16_pkg::PTR_W-1){1'b0}}, pop};
    assign count_next  = count_reg + {{(u8u16_pkg::CNT_W-2){1'b0}}, push_n}
                         - {{(u8u16_pkg::CNT_W-1){1'b0}}, pop};

    // A byte is taken only when the queue can hold both of its possible results.
    assign room  = count_reg <= u8u16_pkg::CNT_W'(u8u16_pkg::QUEUE_DEPTH - 2);
    assign count = count_reg;

    assign out_ch.valid       = count_reg != '0;
    assign out_ch.code_unit   = entry_reg[rd_ptr_reg].code_unit;
    assign out_ch.string_end  = entry_reg[rd_ptr_reg].string_end;
    assign out_ch.last_of_run = entry_reg[rd_ptr_reg].last_of_run;

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0) begin
            entry_reg[wr_ptr_reg] <= dec.first;
        end
        if (push_n == 2'd2) begin
            entry_reg[wr_ptr_plus] <= dec.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### hdl/utf8_to_utf16_decoder.sv
// Top level of the UTF-8 to UTF-16 stream decoder.
// The decoder takes one UTF-8 byte per cycle and returns UTF-16 code units of the Basic
// Multilingual Plane; invalid leads, broken sequences and codes above the plane give 0xFFFD,
// and a zero byte gives a zero unit with string_end set. Each byte is decoded in the cycle it
// is accepted and its zero, one or two results go into a four-word result queue, so a new
// byte is taken every cycle while the queue holds two words or fewer. The sustained rate is
// one byte per cycle while the output is ready, but bytes giving two results slow it, as the
// output drains one word per cycle. last_of_run marks the final word of each byte that gives any.
module utf8_to_utf16_decoder (
    input  logic          clk,
    input  logic          rst_n,
    u8u16_byte_if.sink    in_ch,
    u8u16_unit_if.source  out_ch
);

    u8u16_pkg::decode_t          dec;
    logic [1:0]                  pending;
    logic                        room;
    logic [u8u16_pkg::CNT_W-1:0] count;
    logic                        accept;

    assign in_ch.ready = room;
    assign accept      = in_ch.valid && room;

    u8u16_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (in_ch.in_byte),
        .dec     (dec),
        .pending (pending)
    );

    u8u16_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (accept),
        .dec    (dec),
        .room   (room),
        .count  (count),
        .out_ch (out_ch)
    );

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= u8u16_pkg::CNT_W'(u8u16_pkg::QUEUE_DEPTH))
        else $error("result queue holds more words than its depth");

    a_nul_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_ch.in_byte == 8'd0 |=> pending == 2'd0)
        else $error("sequence still pending after the terminator");

    a_result_shows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && dec.count != 2'd0 |=> out_ch.valid)
        else $error("decoded word did not reach the output");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.string_end |-> out_ch.last_of_run && out_ch.code_unit == 16'd0)
        else $error("end mark on a word that is not the final zero unit");
`endif

endmodule

### test/tb_utf8_to_utf16_decoder.sv
// Self-checking testbench for the UTF-8 to UTF-16 decoder, with a scoreboard of expected words.
`timescale 1ns / 100ps

class utf16_unit_scoreboard;
    u8u16_pkg::result_t expected_units[$];
    logic [20:0]        partial;
    logic [1:0]         pending;
    int                 errors;
    int                 units_checked;
    int                 replacements;
    int                 string_ends;

    function new();
        partial       = 21'd0;
        pending       = 2'd0;
        errors        = 0;
        units_checked = 0;
        replacements  = 0;
        string_ends   = 0;
    endfunction

    function void add_unit(logic [15:0] unit, logic is_end);
        u8u16_pkg::result_t r;
        r.code_unit   = unit;
        r.string_end  = is_end;
        r.last_of_run = 1'b0;
        expected_units.push_back(r);
    endfunction

    // A byte seen while no sequence is open: either a complete unit or a new lead.
    function void start_sequence(logic [7:0] b);
        if (b == 8'd0) begin
            partial = 21'd0;
            pending = 2'd0;
            add_unit(16'd0, 1'b1);
        end else if (b < u8u16_pkg::CONT_MARK) begin
            add_unit({8'd0, b}, 1'b0);
        end else if (b < u8u16_pkg::LEAD_TWO) begin
            add_unit(u8u16_pkg::REPLACEMENT, 1'b0);
        end else if (b < u8u16_pkg::LEAD_THREE) begin
            partial = {16'd0, b[4:0]};
            pending = 2'd1;
        end else if (b < u8u16_pkg::LEAD_FOUR) begin
            partial = {17'd0, b[3:0]};
            pending = 2'd2;
        end else if (b < u8u16_pkg::LEAD_BAD) begin
            partial = {18'd0, b[2:0]};
            pending = 2'd3;
        end else begin
            add_unit(u8u16_pkg::REPLACEMENT, 1'b0);
        end
    endfunction

    function void decode_byte(logic [7:0] b);
        int                 first;
        u8u16_pkg::result_t r;
        first = expected_units.size();
        if (pending == 2'd0) begin
            start_sequence(b);
        end else if (b == 8'd0) begin
            add_unit(u8u16_pkg::REPLACEMENT, 1'b0);
            start_sequence(b);
        end else if ((b & u8u16_pkg::CONT_MASK) == u8u16_pkg::CONT_MARK) begin
            partial = {partial[14:0], b[5:0]};
            pending = pending - 2'd1;
            if (pending == 2'd0) begin
                add_unit(partial < 21'h10000 ? partial[15:0] : u8u16_pkg::REPLACEMENT, 1'b0);
                partial = 21'd0;
            end
        end else begin
            // Broken sequence: flag it, then treat the same byte as a fresh lead.
            partial = 21'd0;
            pending = 2'd0;
            add_unit(u8u16_pkg::REPLACEMENT, 1'b0);
            start_sequence(b);
        end
        if (expected_units.size() > first) begin
            r = expected_units.pop_back();
            r.last_of_run = 1'b1;
            expected_units.push_back(r);
        end
    endfunction

    function void check_unit(u8u16_pkg::result_t got);
        u8u16_pkg::result_t want;
        if (expected_units.size() == 0) begin
            $error("unexpected word: code_unit %h string_end %b last_of_run %b",
                   got.code_unit, got.string_end, got.last_of_run);
            errors++;
            return;
        end
        want = expected_units.pop_front();
        units_checked++;
        if (want.code_unit == u8u16_pkg::REPLACEMENT)
            replacements++;
        if (want.string_end)
            string_ends++;
        if (got.code_unit !== want.code_unit) begin
            $error("code_unit: expected %h, actual %h", want.code_unit, got.code_unit);
            errors++;
        end
        if (got.string_end !== want.string_end) begin
            $error("string_end: expected %b, actual %b", want.string_end, got.string_end);
            errors++;
        end
        if (got.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %b, actual %b", want.last_of_run, got.last_of_run);
            errors++;
        end
    endfunction
endclass

module tb_utf8_to_utf16_decoder;

    logic clk;
    logic rst_n;
    bit   quiet;
    int   bytes_sent;
    int   drains;

    utf16_unit_scoreboard sb;

    u8u16_byte_if byte_ch ();
    u8u16_unit_if unit_ch ();

    utf8_to_utf16_decoder uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (byte_ch),
        .out_ch (unit_ch)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && byte_ch.valid && byte_ch.ready)
            sb.decode_byte(byte_ch.in_byte);
    end

    always @(posedge clk)
    begin
        u8u16_pkg::result_t got;
        if (rst_n && unit_ch.valid && unit_ch.ready) begin
            got.code_unit   = unit_ch.code_unit;
            got.string_end  = unit_ch.string_end;
            got.last_of_run = unit_ch.last_of_run;
            sb.check_unit(got);
        end
    end

    // Output back-pressure: outside the quiet phase, ready drops in about a third of the cycles.
    always @(posedge clk)
    begin
        if (!rst_n)
            unit_ch.ready <= 1'b0;
        else
            unit_ch.ready <= quiet || ($urandom_range(99) >= 36);
    end

    task automatic send_byte(input logic [7:0] b);
        while (!quiet && $urandom_range(99) < 36) begin
            byte_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.in_byte <= b;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Hold off the sender until every predicted word has come out.
    task automatic wait_for_drain();
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_units.size() != 0)
            @(posedge clk);
        drains++;
    endtask

    function automatic logic [7:0] cont_byte();
        return u8u16_pkg::CONT_MARK | 8'($urandom_range(0, 63));
    endfunction

    // Lead byte of a len-byte sequence followed by keep continuation bytes.
    task automatic send_sequence(input int len, input int keep);
        logic [7:0] lead;
        case (len)
            2:       lead = 8'($urandom_range(8'hC2, 8'hDF));
            3:       lead = 8'($urandom_range(8'hE0, 8'hEF));
            default: lead = 8'($urandom_range(8'hF0, 8'hF4));
        endcase
        send_byte(lead);
        for (int i = 0; i < keep; i++)
            send_byte(cont_byte());
    endtask

    task automatic send_random_char();
        int         kind;
        int         len;
        logic [7:0] b;
        kind = $urandom_range(99);
        if (kind < 30) begin
            send_byte(8'($urandom_range(1, 127)));
        end else if (kind < 50) begin
            send_sequence(2, 1);
        end else if (kind < 68) begin
            send_sequence(3, 2);
        end else if (kind < 80) begin
            send_sequence(4, 3);
        end else if (kind < 86) begin
            send_byte(8'd0);
            if ($urandom_range(5) == 0)
                wait_for_drain();
        end else if (kind < 93) begin
            send_byte(8'($urandom_range(0, 255)));
        end else begin
            // Sequence cut short by a byte that is not a continuation, NUL included.
            len = $urandom_range(2, 4);
            send_sequence(len, $urandom_range(0, len - 2));
            b = 8'($urandom_range(0, 255));
            if ((b & u8u16_pkg::CONT_MASK) == u8u16_pkg::CONT_MARK)
                b = b | 8'h40;
            if ($urandom_range(4) == 0)
                b = 8'd0;
            send_byte(b);
        end
    endtask

    initial
    begin
        logic [7:0] directed[$];
        int         guard;
        sb              = new();
        quiet           = 1'b0;
        bytes_sent      = 0;
        drains          = 0;
        rst_n           = 1'b0;
        byte_ch.valid   = 1'b0;
        byte_ch.in_byte = 8'd0;
        unit_ch.ready   = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // NUL, ASCII limits, bad leads, shortest and longest plane codes, an overlong
        // form, a code above the plane, broken continuations and a NUL inside a sequence.
        directed = '{8'h00, 8'h41, 8'h7F, 8'h80, 8'hC2, 8'h80, 8'hDF, 8'hBF,
                     8'hE0, 8'h80, 8'h80, 8'hEF, 8'hBF, 8'hBF,
                     8'hF0, 8'h90, 8'h80, 8'h80, 8'hF5, 8'hFF,
                     8'hC3, 8'h41, 8'hE2, 8'h00, 8'hE2, 8'h82, 8'hC3, 8'hA9};
        foreach (directed[i])
            send_byte(directed[i]);
        wait_for_drain();

        while (bytes_sent < 950) begin
            quiet = (bytes_sent >= 350 && bytes_sent < 550);
            send_random_char();
        end
        quiet = 1'b0;
        byte_ch.valid <= 1'b0;
        @(posedge clk);

        guard = 0;
        while (sb.expected_units.size() != 0 && guard < 20000) begin
            @(posedge clk);
            guard++;
        end
        repeat (20) @(posedge clk);

        if (sb.expected_units.size() != 0) begin
            $error("%0d expected words never arrived", sb.expected_units.size());
            sb.errors++;
        end
        $display("Decoded %0d bytes into %0d words: %0d replacement units, %0d string ends.",
                 bytes_sent, sb.units_checked, sb.replacements, sb.string_ends);
        $display("The sender was held until the output drained %0d times.", drains);
        if (sb.errors == 0)
            $display("tb_utf8_to_utf16_decoder: clean");
        else
            $display("tb_utf8_to_utf16_decoder: errors");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("tb_utf8_to_utf16_decoder: errors");
        $finish;
    end

endmodule

### utf8_to_utf16_decoder.f
hdl/u8u16_pkg.sv
hdl/u8u16_if.sv
hdl/u8u16_decode.sv
hdl/u8u16_queue.sv
hdl/utf8_to_utf16_decoder.sv
test/tb_utf8_to_utf16_decoder.sv
